[rtl/abo_pkg.sv]
// ----------------------------------------------------------------------------
// abo_pkg
// Shared widths and constants of the source-over alpha blender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package abo_pkg;

  // Full effective alpha: 255 * 255.
  localparam logic [15:0] FullProduct = 16'd65025;

  // Quotient bits of every blend division; the quotient never exceeds 255.
  localparam int unsigned DivSteps = 8;

  localparam int unsigned NumWidth = 32;  // colour numerator, at most 255 * OA
  localparam int unsigned DenWidth = 24;  // OA, at most 255 * 65025

  // floor(OA / 65025) equals (OA * AlphaRecip) >> AlphaShift over all OA
  localparam int unsigned AlphaShift = 40;
  localparam logic [24:0] AlphaRecip = 25'd16909061;

  typedef logic [NumWidth-1:0] num_t;
  typedef logic [DenWidth-1:0] den_t;
  typedef logic [DivSteps-1:0] quo_t;

endpackage

[rtl/abo_div_lane.sv]
// ----------------------------------------------------------------------------
// abo_div_lane
// Pipelined restoring divider: one quotient bit per register stage, eight
// stages, a new operand pair every cycle. The quotient must fit in 8 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abo_div_lane
  import abo_pkg::*;
(
  input  logic clk_i,
  input  num_t num_i,
  input  den_t den_i,
  output quo_t quo_o
);

  num_t rem_q [DivSteps];
  den_t den_q [DivSteps];
  quo_t quo_q [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    localparam int unsigned Shift = DivSteps - 1 - k;

    num_t rem_in;
    den_t den_in;
    quo_t quo_in;
    num_t trial;
    logic ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = NumWidth'(den_in) << Shift;
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? (rem_in - trial) : rem_in;
      den_q[k] <= den_in;
      quo_q[k] <= {quo_in[DivSteps-2:0], ge};
    end
  end

  assign quo_o = quo_q[DivSteps-1];

endmodule

[rtl/alpha_over_blend.sv]
// ----------------------------------------------------------------------------
// alpha_over_blend
// Non-premultiplied source-over compositing of one RGBA source pixel, scaled
// by an 8-bit opacity, onto one RGBA destination pixel, exact in integers.
//
// A pixel beat is taken at each rising edge with start_i high and busy_o low.
// busy_o is always low: the pipeline takes one pixel every cycle.
// The blended pixel appears on out_*_o with done_o high once the beat has
// passed every register stage listed below, in the order of entry.
// Throughput is one pixel per clock, set by the fully pipelined datapath:
// three multiply stages (effective alpha; channel products; numerators and
// coverage), eight restoring-divide stages of one quotient bit each for the
// colours, with the coverage scaled by a reciprocal multiply and delayed to
// match, and an output register.
// The receiver cannot stall; results are never held back or repeated.
// Zero coverage (both alphas effectively zero) gives an all-zero pixel.
// Reset clears the valid bits only, so no strobe follows reset until a
// beat is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alpha_over_blend
  import abo_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [7:0] dst_red_i,
  input  logic [7:0] dst_green_i,
  input  logic [7:0] dst_blue_i,
  input  logic [7:0] dst_a_i,
  input  logic [7:0] src_red_i,
  input  logic [7:0] src_green_i,
  input  logic [7:0] src_blue_i,
  input  logic [7:0] src_a_i,
  input  logic [7:0] opacity_i,
  output logic       done_o,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_a_o
);

  localparam int unsigned NumCh = 3;

  // stage 1: effective source alpha
  logic        s1_vld_q;
  logic [15:0] s1_a_q;
  logic [7:0]  s1_da_q;
  logic [7:0]  s1_sc_q [NumCh];
  logic [7:0]  s1_dc_q [NumCh];

  // stage 2: per-channel products
  logic        s2_vld_q;
  logic [15:0] s2_p_q;
  logic [23:0] s2_t_q;
  logic [7:0]  s2_da_q;
  logic [23:0] s2_sca_q [NumCh];
  logic [15:0] s2_dcd_q [NumCh];

  // stage 3: numerators and coverage
  logic        s3_vld_q;
  logic        s3_zero_q;
  den_t        s3_oa_q;
  num_t        s3_num_q [NumCh];

  logic [DivSteps-1:0] dv_vld_q;
  logic [DivSteps-1:0] dv_zero_q;

  quo_t ch_quo [NumCh];
  logic [7:0] al_q [DivSteps];

  logic       out_vld_q;
  logic [7:0] out_ch_q [NumCh];
  logic [7:0] out_al_q;

  logic [7:0] in_sc [NumCh];
  logic [7:0] in_dc [NumCh];

  assign busy_o = 1'b0;

  assign in_sc[0] = src_red_i;
  assign in_sc[1] = src_green_i;
  assign in_sc[2] = src_blue_i;
  assign in_dc[0] = dst_red_i;
  assign in_dc[1] = dst_green_i;
  assign in_dc[2] = dst_blue_i;

  // valid and zero-coverage tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= start_i & ~busy_o;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      dv_vld_q  <= {dv_vld_q[DivSteps-2:0], s3_vld_q};
      out_vld_q <= dv_vld_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_zero_q <= {dv_zero_q[DivSteps-2:0], s3_zero_q};
  end

  // datapath
  always_ff @(posedge clk_i) begin
    s1_a_q  <= 16'(src_a_i) * 16'(opacity_i);
    s1_da_q <= dst_a_i;

    s2_p_q  <= FullProduct - s1_a_q;
    s2_t_q  <= (24'(s1_a_q) << 8) - 24'(s1_a_q);
    s2_da_q <= s1_da_q;

    s3_oa_q   <= s2_t_q + 24'(s2_da_q) * 24'(s2_p_q);
    s3_zero_q <= (s2_t_q == '0) && ((s2_da_q == '0) || (s2_p_q == '0));
  end

  for (genvar c = 0; c < NumCh; c++) begin : g_ch
    always_ff @(posedge clk_i) begin
      s1_sc_q[c]  <= in_sc[c];
      s1_dc_q[c]  <= in_dc[c];
      s2_sca_q[c] <= 24'(s1_sc_q[c]) * 24'(s1_a_q);
      s2_dcd_q[c] <= 16'(s1_dc_q[c]) * 16'(s1_da_q);
      s3_num_q[c] <= ((NumWidth'(s2_sca_q[c]) << 8) - NumWidth'(s2_sca_q[c]))
                   + NumWidth'(s2_dcd_q[c]) * NumWidth'(s2_p_q);
    end

    abo_div_lane u_div (
      .clk_i (clk_i),
      .num_i (s3_num_q[c]),
      .den_i (s3_oa_q),
      .quo_o (ch_quo[c])
    );

    always_ff @(posedge clk_i) begin
      out_ch_q[c] <= dv_zero_q[DivSteps-1] ? 8'd0 : ch_quo[c];
    end
  end

  // scale coverage by the reciprocal of 65025, then hold it beside the dividers
  always_ff @(posedge clk_i) begin
    al_q[0] <= 8'((48'(s3_oa_q) * 48'(AlphaRecip)) >> AlphaShift);
    for (int unsigned k = 1; k < DivSteps; k++) begin
      al_q[k] <= al_q[k-1];
    end
    out_al_q <= al_q[DivSteps-1];
  end

  assign done_o      = out_vld_q;
  assign out_red_o   = out_ch_q[0];
  assign out_green_o = out_ch_q[1];
  assign out_blue_o  = out_ch_q[2];
  assign out_a_o     = out_al_q;

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for alpha_over_blend. A queue of pixel beats, directed
// corner cases first and then random pixels in phases with different source
// idle rates, feeds a clocked driver. A clocked monitor compares each blended
// pixel with the oldest prediction of an exact integer source-over model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
  import abo_pkg::*;
();

  typedef struct packed {
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_a;
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_a;
    logic [7:0] opacity;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct {
    pixel_t      px;
    int unsigned idle_pct;
    bit          drain;
  } beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  pixel_t     px_d = '0;
  logic       busy_o;
  logic       done_o;
  logic [7:0] out_red_o;
  logic [7:0] out_green_o;
  logic [7:0] out_blue_o;
  logic [7:0] out_a_o;

  beat_t source_beats[$];
  rgba_t blended_q[$];
  int    error_count = 0;

  alpha_over_blend dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .dst_red_i   (px_d.dst_red),
    .dst_green_i (px_d.dst_green),
    .dst_blue_i  (px_d.dst_blue),
    .dst_a_i     (px_d.dst_a),
    .src_red_i   (px_d.src_red),
    .src_green_i (px_d.src_green),
    .src_blue_i  (px_d.src_blue),
    .src_a_i     (px_d.src_a),
    .opacity_i   (px_d.opacity),
    .done_o      (done_o),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .out_a_o     (out_a_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [7:0] blend_chan(longint unsigned sc, longint unsigned dc,
                                            longint unsigned a, longint unsigned d,
                                            longint unsigned oa);
    longint unsigned full;
    longint unsigned q;
    full = longint'(FullProduct);
    q = (64'd255 * sc * a + dc * d * (full - a)) / oa;
    return (q > 64'd255) ? 8'd255 : q[7:0];
  endfunction

  function automatic rgba_t blend_over(pixel_t p);
    longint unsigned full;
    longint unsigned a;
    longint unsigned d;
    longint unsigned oa;
    longint unsigned cov;
    rgba_t r;
    full = longint'(FullProduct);
    a = longint'(p.src_a) * longint'(p.opacity);
    d = longint'(p.dst_a);
    oa = 64'd255 * a + d * (full - a);
    r = '0;
    if (oa != 0) begin
      cov = oa / full;
      r.alpha = (cov > 64'd255) ? 8'd255 : cov[7:0];
      r.red   = blend_chan(p.src_red,   p.dst_red,   a, d, oa);
      r.green = blend_chan(p.src_green, p.dst_green, a, d, oa);
      r.blue  = blend_chan(p.src_blue,  p.dst_blue,  a, d, oa);
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      3: return 8'd254;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.dst_red   = pick_byte();
    p.dst_green = pick_byte();
    p.dst_blue  = pick_byte();
    p.dst_a     = pick_byte();
    p.src_red   = pick_byte();
    p.src_green = pick_byte();
    p.src_blue  = pick_byte();
    p.src_a     = pick_byte();
    p.opacity   = pick_byte();
    if ($urandom_range(15) == 0) begin
      p.dst_a = 8'd0;
      if ($urandom_range(1) == 0) p.src_a = 8'd0;
      else p.opacity = 8'd0;
    end
    return p;
  endfunction

  task automatic add_beat(pixel_t p, int unsigned idle_pct, bit drain);
    beat_t b;
    b.px = p;
    b.idle_pct = idle_pct;
    b.drain = drain;
    source_beats.push_back(b);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : drive
    bit    taken;
    beat_t nb;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      taken = start_i && !busy_o;
      if (taken) blended_q.push_back(blend_over(px_d));
      if (start_i && !taken) begin
        // hold the beat until it is taken
      end else if (source_beats.size() == 0) begin
        start_i <= 1'b0;
      end else if (source_beats[0].drain && blended_q.size() != 0) begin
        start_i <= 1'b0;
      end else if ($urandom_range(99) < source_beats[0].idle_pct) begin
        start_i <= 1'b0;
      end else begin
        nb = source_beats.pop_front();
        px_d <= nb.px;
        start_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watch
    rgba_t want;
    if (rst_ni && done_o) begin
      if (blended_q.size() == 0) begin
        $error("unexpected pixel r=%0d g=%0d b=%0d a=%0d",
               out_red_o, out_green_o, out_blue_o, out_a_o);
        error_count++;
      end else begin
        want = blended_q.pop_front();
        check_field("out_red",   want.red,   out_red_o);
        check_field("out_green", want.green, out_green_o);
        check_field("out_blue",  want.blue,  out_blue_o);
        check_field("out_a",     want.alpha, out_a_o);
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_idle[6];
    phase_idle = '{0, 80, 18, 0, 80, 18};

    add_beat(pixel_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 0, 0);
    add_beat(pixel_t'{8'd255, 8'd255, 8'd255, 8'd255,
                      8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 0, 0);
    add_beat(pixel_t'{8'd255, 8'd255, 8'd255, 8'd0,
                      8'd255, 8'd255, 8'd255, 8'd0, 8'd255}, 0, 0);
    add_beat(pixel_t'{8'd255, 8'd255, 8'd255, 8'd0,
                      8'd255, 8'd255, 8'd255, 8'd255, 8'd0}, 0, 0);
    add_beat(pixel_t'{8'd12, 8'd200, 8'd99, 8'd255,
                      8'd255, 8'd0, 8'd7, 8'd0, 8'd255}, 0, 0);
    add_beat(pixel_t'{8'd12, 8'd200, 8'd99, 8'd0,
                      8'd255, 8'd0, 8'd7, 8'd255, 8'd255}, 0, 0);
    add_beat(pixel_t'{8'd255, 8'd128, 8'd1, 8'd1,
                      8'd0, 8'd0, 8'd0, 8'd0, 8'd255}, 0, 0);
    add_beat(pixel_t'{8'd0, 8'd0, 8'd0, 8'd0,
                      8'd255, 8'd254, 8'd1, 8'd1, 8'd1}, 0, 0);
    add_beat(pixel_t'{8'd0, 8'd0, 8'd0, 8'd255,
                      8'd255, 8'd255, 8'd255, 8'd255, 8'd1}, 0, 0);
    add_beat(pixel_t'{8'd255, 8'd0, 8'd255, 8'd128,
                      8'd0, 8'd255, 8'd0, 8'd1, 8'd255}, 0, 0);
    add_beat(pixel_t'{8'hAA, 8'hAA, 8'hAA, 8'hAA,
                      8'h55, 8'h55, 8'h55, 8'h55, 8'h55}, 0, 0);
    add_beat(pixel_t'{8'h55, 8'h55, 8'h55, 8'h55,
                      8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA}, 0, 0);
    add_beat(pixel_t'{8'd128, 8'd64, 8'd32, 8'd128,
                      8'd16, 8'd8, 8'd4, 8'd128, 8'd128}, 0, 0);
    add_beat(pixel_t'{8'd0, 8'd0, 8'd0, 8'd255,
                      8'd255, 8'd255, 8'd255, 8'd255, 8'd254}, 0, 0);
    add_beat(pixel_t'{8'd255, 8'd255, 8'd255, 8'd254,
                      8'd0, 8'd0, 8'd0, 8'd254, 8'd255}, 0, 0);

    foreach (phase_idle[ph]) begin
      for (int i = 0; i < 67; i++) add_beat(rand_pixel(), phase_idle[ph], i == 0);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (source_beats.size() != 0 || start_i || blended_q.size() != 0);
    repeat (30) @(posedge clk_i);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
